### design/lzss_ring_dictionary_decoder_top_assert.svh
// assertion macros used by the lzss decoder port checker
`ifndef LZSS_RING_DICTIONARY_DECODER_TOP_ASSERT_SVH
`define LZSS_RING_DICTIONARY_DECODER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define LZSSD_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define LZSSD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/lzssd_pkg.sv
// shared types and constants of the lzss ring dictionary decoder
package lzssd_pkg;

   localparam int WINDOW_DEPTH = 1024;
   localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
   localparam int FILL_W       = WIN_AW + 1;
   localparam int CNT_W        = 7;

   localparam logic [WIN_AW-1:0] WIN_START = WIN_AW'(10'h3BE);
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_DEPTH);
   localparam logic [31:0]       SIZE_BIAS = 32'h0000_000C;
   localparam logic [CNT_W-1:0]  LEN_BIAS  = CNT_W'(3);
   localparam logic [7:0]        FLAG_FILL = 8'hFF;
   localparam logic [2:0]        HDR_LEN   = 3'd4;

   typedef enum logic [1:0] {
      PH_TOKEN,
      PH_BODY,
      PH_REF_LO
   } phase_type;

   typedef enum logic [1:0] {
      ENG_IDLE,
      ENG_LIT,
      ENG_COPY
   } eng_state_type;

   typedef struct packed {
      logic              clear;
      logic              load;
      logic [31:0]       load_value;
      logic              literal;
      logic              copy;
      logic [7:0]        data;
      logic [WIN_AW-1:0] offset;
      logic [CNT_W-1:0]  count;
   } cmd_type;

   typedef struct packed {
      logic idle;
      logic rem_zero;
   } status_type;

endpackage

### design/lzssd_dict_ram.sv
// history window memory: one write port, one registered read port
module lzssd_dict_ram
   import lzssd_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [WIN_AW-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic [WIN_AW-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem_ff [WINDOW_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/lzssd_parser.sv
// stream parser: size header, flag bits and token bytes into engine commands
module lzssd_parser
   import lzssd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_stream_start,
   input  status_type status,
   output cmd_type    cmd
);

   logic [2:0]  hdr_ff, hdr_in;
   logic [23:0] acc_ff, acc_in;
   phase_type   phase_ff, phase_in;
   logic [15:0] flag_ff, flag_in;
   logic [7:0]  refhi_ff, refhi_in;

   logic        accept;
   logic [2:0]  eff_hdr;
   logic [23:0] eff_acc;
   phase_type   eff_phase;
   logic [15:0] eff_flag;
   logic [7:0]  eff_refhi;
   logic [15:0] shifted;
   logic [31:0] size_word;
   logic        body;
   logic        body_bit;

   assign accept = req_valid && req_ready;

   always_comb begin
      eff_hdr   = req_stream_start ? 3'd0 : hdr_ff;
      eff_acc   = req_stream_start ? 24'd0 : acc_ff;
      eff_phase = req_stream_start ? PH_TOKEN : phase_ff;
      eff_flag  = req_stream_start ? 16'd0 : flag_ff;
      eff_refhi = req_stream_start ? 8'd0 : refhi_ff;
      shifted   = {1'b0, eff_flag[15:1]};
      size_word = {eff_acc, req_in_byte};

      hdr_in   = hdr_ff;
      acc_in   = acc_ff;
      phase_in = phase_ff;
      flag_in  = flag_ff;
      refhi_in = refhi_ff;
      cmd      = '0;
      body     = 1'b0;
      body_bit = 1'b0;

      if (accept) begin
         cmd.clear = req_stream_start;
         hdr_in    = eff_hdr;
         acc_in    = eff_acc;
         phase_in  = eff_phase;
         flag_in   = eff_flag;
         refhi_in  = eff_refhi;
         if (eff_hdr != HDR_LEN) begin
            acc_in = {eff_acc[15:0], req_in_byte};
            hdr_in = eff_hdr + 3'd1;
            if (eff_hdr == HDR_LEN - 3'd1) begin
               cmd.load       = 1'b1;
               cmd.load_value = (size_word < SIZE_BIAS) ? 32'd0 : size_word - SIZE_BIAS;
            end
         end else if (!status.rem_zero) begin
            unique case (eff_phase)
               PH_TOKEN: begin
                  if (!shifted[8]) begin
                     // flag bits used up: this byte is a new flag byte
                     flag_in  = {FLAG_FILL, req_in_byte};
                     phase_in = PH_BODY;
                  end else begin
                     flag_in  = shifted;
                     body     = 1'b1;
                     body_bit = shifted[0];
                  end
               end
               PH_BODY: begin
                  body     = 1'b1;
                  body_bit = eff_flag[0];
               end
               PH_REF_LO: begin
                  cmd.copy   = 1'b1;
                  cmd.offset = {eff_refhi[1:0], req_in_byte};
                  cmd.count  = {1'b0, eff_refhi[7:2]} + LEN_BIAS;
                  phase_in   = PH_TOKEN;
               end
               default: begin
                  phase_in = PH_TOKEN;
               end
            endcase
            if (body) begin
               if (body_bit) begin
                  cmd.literal = 1'b1;
                  cmd.data    = req_in_byte;
                  phase_in    = PH_TOKEN;
               end else begin
                  refhi_in = req_in_byte;
                  phase_in = PH_REF_LO;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff   <= 3'd0;
         acc_ff   <= 24'd0;
         phase_ff <= PH_TOKEN;
         flag_ff  <= 16'd0;
         refhi_ff <= 8'd0;
      end else begin
         hdr_ff   <= hdr_in;
         acc_ff   <= acc_in;
         phase_ff <= phase_in;
         flag_ff  <= flag_in;
         refhi_ff <= refhi_in;
      end
   end

endmodule

### design/lzssd_engine.sv
// copy sequencer: literal and back-reference bytes, window writes, result pairing
module lzssd_engine
   import lzssd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output status_type        status,
   output logic              wr_en,
   output logic [WIN_AW-1:0] wr_addr,
   output logic [7:0]        wr_data,
   output logic [WIN_AW-1:0] rd_addr,
   input  logic [7:0]        rd_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_out_byte_a,
   output logic [7:0]        rsp_out_byte_b,
   output logic [1:0]        rsp_out_count,
   output logic              rsp_run_last,
   output logic              rsp_stream_done
);

   eng_state_type     state_ff, state_in;
   logic [31:0]       rem_ff, rem_in;
   logic [WIN_AW-1:0] wp_ff, wp_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [7:0]        lit_ff, lit_in;
   logic [WIN_AW-1:0] src_ff, src_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [7:0]        pend_ff, pend_in;
   logic              pend_vld_ff, pend_vld_in;
   logic              rd_ok_ff, rd_ok_in;
   logic              fwd_ff, fwd_in;
   logic [7:0]        fwd_data_ff, fwd_data_in;

   logic              rsp_valid_ff;
   logic [7:0]        rsp_a_ff, rsp_b_ff;
   logic [1:0]        rsp_cnt_ff;
   logic              rsp_last_ff, rsp_done_ff;

   logic              out_free;
   logic              rem_done;
   logic [7:0]        copy_byte;
   logic              last;
   logic              adv;
   logic [WIN_AW-1:0] rd_rel;
   logic              push;
   logic [7:0]        push_a, push_b;
   logic [1:0]        push_cnt;
   logic              push_last;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rem_done  = (rem_ff == 32'd1);
   assign copy_byte = fwd_ff ? fwd_data_ff : (rd_ok_ff ? rd_data : 8'h00);
   assign last      = (cnt_ff == CNT_W'(1)) || rem_done;

   always_comb begin
      state_in    = state_ff;
      rem_in      = rem_ff;
      wp_in       = wp_ff;
      fill_in     = fill_ff;
      lit_in      = lit_ff;
      src_in      = src_ff;
      cnt_in      = cnt_ff;
      pend_in     = pend_ff;
      pend_vld_in = pend_vld_ff;
      fwd_in      = 1'b0;
      fwd_data_in = copy_byte;
      rd_addr     = src_ff;
      wr_en       = 1'b0;
      wr_addr     = wp_ff;
      wr_data     = copy_byte;
      adv         = 1'b0;
      push        = 1'b0;
      push_a      = 8'h00;
      push_b      = 8'h00;
      push_cnt    = 2'd1;
      push_last   = 1'b1;

      unique case (state_ff)
         ENG_IDLE: begin
            if (cmd.clear) begin
               rem_in  = 32'd0;
               wp_in   = WIN_START;
               fill_in = '0;
            end
            if (cmd.load) begin
               rem_in = cmd.load_value;
            end
            if (cmd.literal) begin
               lit_in   = cmd.data;
               state_in = ENG_LIT;
            end
            if (cmd.copy) begin
               src_in   = cmd.offset;
               rd_addr  = cmd.offset;
               cnt_in   = cmd.count;
               state_in = ENG_COPY;
            end
         end
         ENG_LIT: begin
            if (out_free) begin
               wr_en    = 1'b1;
               wr_data  = lit_ff;
               push     = 1'b1;
               push_a   = lit_ff;
               state_in = ENG_IDLE;
            end
         end
         ENG_COPY: begin
            adv = !(pend_vld_ff || last) || out_free;
            if (adv) begin
               wr_en       = 1'b1;
               wr_data     = copy_byte;
               src_in      = src_ff + WIN_AW'(1);
               rd_addr     = src_ff + WIN_AW'(1);
               // next read hits the entry written now: take the byte directly
               fwd_in      = (src_in == wp_ff);
               fwd_data_in = copy_byte;
               cnt_in      = cnt_ff - CNT_W'(1);
               if (pend_vld_ff) begin
                  push        = 1'b1;
                  push_a      = pend_ff;
                  push_b      = copy_byte;
                  push_cnt    = 2'd2;
                  push_last   = last;
                  pend_vld_in = 1'b0;
               end else if (last) begin
                  push   = 1'b1;
                  push_a = copy_byte;
               end else begin
                  pend_in     = copy_byte;
                  pend_vld_in = 1'b1;
               end
               if (last) begin
                  state_in = ENG_IDLE;
               end
            end
         end
         default: begin
            state_in = ENG_IDLE;
         end
      endcase

      if (wr_en) begin
         wp_in   = wp_ff + WIN_AW'(1);
         fill_in = (fill_ff == FILL_FULL) ? fill_ff : fill_ff + FILL_W'(1);
         rem_in  = rem_ff - 32'd1;
      end

      // entries outside the written run since stream start read as zero
      rd_rel   = rd_addr - WIN_START;
      rd_ok_in = ({1'b0, rd_rel} < fill_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ENG_IDLE;
         rem_ff      <= 32'd0;
         wp_ff       <= WIN_START;
         fill_ff     <= '0;
         pend_vld_ff <= 1'b0;
         fwd_ff      <= 1'b0;
         rd_ok_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rem_ff      <= rem_in;
         wp_ff       <= wp_in;
         fill_ff     <= fill_in;
         pend_vld_ff <= pend_vld_in;
         fwd_ff      <= fwd_in;
         rd_ok_ff    <= rd_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      lit_ff      <= lit_in;
      src_ff      <= src_in;
      cnt_ff      <= cnt_in;
      pend_ff     <= pend_in;
      fwd_data_ff <= fwd_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_a_ff    <= push_a;
         rsp_b_ff    <= push_b;
         rsp_cnt_ff  <= push_cnt;
         rsp_last_ff <= push_last;
         rsp_done_ff <= rem_done;
      end
   end

   assign status.idle     = (state_ff == ENG_IDLE);
   assign status.rem_zero = (rem_ff == 32'd0);

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte_a  = rsp_a_ff;
   assign rsp_out_byte_b  = rsp_b_ff;
   assign rsp_out_count   = rsp_cnt_ff;
   assign rsp_run_last    = rsp_last_ff;
   assign rsp_stream_done = rsp_done_ff;

endmodule

### design/lzss_ring_dictionary_decoder_top.sv
// top level of the lzss ring dictionary decoder
// header, flag and reference-high bytes give no result, the sequencer stays idle;
// a literal keeps the sequencer busy until ENG_LIT writes it and registers its result;
// a back-reference of n bytes, at most 66, is copied one byte per cycle while the
// output register is free, through the single read port of the 1024-byte window
// reset: synchronous, equals the start of a fresh stream, no clearing pass needed
module lzss_ring_dictionary_decoder_top
   import lzssd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_stream_start,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte_a,
   output logic [7:0] rsp_out_byte_b,
   output logic [1:0] rsp_out_count,
   output logic       rsp_run_last,
   output logic       rsp_stream_done
);

   // command from the byte parser to the copy sequencer
   cmd_type           cmd;
   // sequencer idle and length-exhausted flags back to the parser
   status_type        status;

   // window memory port
   logic              wr_en;
   logic [WIN_AW-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic [WIN_AW-1:0] rd_addr;
   logic [7:0]        rd_data;

   // a new byte is taken only while the sequencer has no work in flight
   assign req_ready = status.idle;

   // header collection, flag bit tracking and token decode
   lzssd_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_byte      (req_in_byte),
      .req_stream_start (req_stream_start),
      .status           (status),
      .cmd              (cmd)
   );

   // literal and copy sequencer, owns the output register
   lzssd_engine u_engine (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .wr_en           (wr_en),
      .wr_addr         (wr_addr),
      .wr_data         (wr_data),
      .rd_addr         (rd_addr),
      .rd_data         (rd_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte_a  (rsp_out_byte_a),
      .rsp_out_byte_b  (rsp_out_byte_b),
      .rsp_out_count   (rsp_out_count),
      .rsp_run_last    (rsp_run_last),
      .rsp_stream_done (rsp_stream_done)
   );

   // history window; stale entries are masked by the fill count in the engine
   lzssd_dict_ram u_dict (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

### design/lzssd_checker.sv
// port-level checks of the lzss decoder and their bind to the top level
`include "lzss_ring_dictionary_decoder_top_assert.svh"

module lzssd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_in_byte,
   input logic       req_stream_start,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte_a,
   input logic [7:0] rsp_out_byte_b,
   input logic [1:0] rsp_out_count,
   input logic       rsp_run_last,
   input logic       rsp_stream_done
);

   `LZSSD_ASSERT_IMPL(a_count_range, rsp_valid, rsp_out_count == 2'd1 || rsp_out_count == 2'd2, "result count out of range")
   `LZSSD_ASSERT_IMPL(a_single_b_zero, rsp_valid && rsp_out_count == 2'd1, rsp_out_byte_b == 8'h00, "second byte not zero")
   `LZSSD_ASSERT_IMPL(a_done_is_last, rsp_valid && rsp_stream_done, rsp_run_last, "stream done on a non-final result")
   `LZSSD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_byte_a) && $stable(rsp_out_byte_b) && $stable(rsp_out_count), "stalled result changed")

endmodule

bind lzss_ring_dictionary_decoder_top lzssd_checker u_checker (.*);

### dv/lzss_ring_dictionary_decoder_checker.sv
// result checker for the lzss ring dictionary decoder: decodes alongside the block and compares
module lzss_ring_dictionary_decoder_checker
   import lzssd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_stream_start,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_out_byte_a,
   input  logic [7:0] rsp_out_byte_b,
   input  logic [1:0] rsp_out_count,
   input  logic       rsp_run_last,
   input  logic       rsp_stream_done,
   output int         fail_count,
   output int         pending,
   output int         chunks_checked
);

   typedef struct packed {
      logic [7:0] byte_a;
      logic [7:0] byte_b;
      logic [1:0] count;
      logic       last;
      logic       done;
   } chunk_type;

   chunk_type  chunk_q[$];
   logic [7:0] window_mem[WINDOW_DEPTH];
   logic [9:0] wr_pos;
   logic [15:0] flag_bits;
   logic [31:0] out_left;
   logic [2:0] size_bytes_seen;
   phase_type  phase;
   logic [7:0] ref_high_byte;
   logic [7:0] pend_a, pend_b;
   int         pend_n;
   int         fails = 0;
   int         checked = 0;

   assign fail_count     = fails;
   assign chunks_checked = checked;

   task clear_stream();
      foreach (window_mem[i]) window_mem[i] = 8'h00;
      wr_pos          = WIN_START;
      flag_bits       = '0;
      out_left        = '0;
      size_bytes_seen = '0;
      phase           = PH_TOKEN;
      ref_high_byte   = '0;
   endtask

   task flush_chunk();
      chunk_q.push_back('{byte_a: pend_a, byte_b: (pend_n == 2) ? pend_b : 8'h00,
                          count: 2'(pend_n), last: 1'b0, done: (out_left == 0)});
      pend_n = 0;
   endtask

   // every decoded byte goes back into the window and into the pending chunk
   task put_byte(input logic [7:0] v);
      window_mem[wr_pos] = v;
      wr_pos++;
      out_left--;
      if (pend_n == 0) begin
         pend_a = v;
         pend_n = 1;
      end else begin
         pend_b = v;
         pend_n = 2;
         flush_chunk();
      end
   endtask

   task decode_byte(input logic [7:0] b, input logic start);
      int          first;
      logic [15:0] shifted;
      logic [15:0] spec;
      logic [6:0]  run;
      logic [9:0]  src;
      chunk_type   tail;
      bit          body;
      first  = chunk_q.size();
      pend_n = 0;
      if (start) clear_stream();
      if (size_bytes_seen < HDR_LEN) begin
         out_left = {out_left[23:0], b};
         size_bytes_seen++;
         if (size_bytes_seen == HDR_LEN)
            out_left = (out_left < SIZE_BIAS) ? '0 : out_left - SIZE_BIAS;
      end else if (out_left != 0) begin
         body = 1'b1;
         if (phase == PH_TOKEN) begin
            shifted = {1'b0, flag_bits[15:1]};
            if (!shifted[8]) begin
               // flag byte used up, this byte is the next one
               flag_bits = {FLAG_FILL, b};
               body = 1'b0;
            end else begin
               flag_bits = shifted;
            end
            phase = PH_BODY;
         end
         if (body) begin
            if (phase == PH_BODY) begin
               if (flag_bits[0]) begin
                  put_byte(b);
                  phase = PH_TOKEN;
               end else begin
                  ref_high_byte = b;
                  phase = PH_REF_LO;
               end
            end else begin
               spec = {ref_high_byte, b};
               run  = {1'b0, spec[15:10]} + LEN_BIAS;
               src  = spec[9:0];
               // byte by byte so that overlapping copies repeat bytes
               for (int z = 0; z < run && out_left != 0; z++) begin
                  put_byte(window_mem[src]);
                  src++;
               end
               phase = PH_TOKEN;
            end
            if (pend_n != 0) flush_chunk();
            if (chunk_q.size() > first) begin
               tail = chunk_q.pop_back();
               tail.last = 1'b1;
               chunk_q.push_back(tail);
            end
         end
      end
   endtask

   task check_field(input string what, input logic [7:0] exp_v, input logic [7:0] got_v);
      if (got_v !== exp_v) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, exp_v, got_v);
         fails++;
      end
   endtask

   always @(posedge clock) begin
      chunk_type want;
      if (reset) begin
         clear_stream();
         chunk_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (chunk_q.size() == 0) begin
               $display("%0t: unexpected result, expected none, got a=%0h b=%0h n=%0d",
                        $time, rsp_out_byte_a, rsp_out_byte_b, rsp_out_count);
               fails++;
            end else begin
               want = chunk_q.pop_front();
               check_field("out_byte_a", want.byte_a, rsp_out_byte_a);
               check_field("out_byte_b", want.byte_b, rsp_out_byte_b);
               check_field("out_count", 8'(want.count), 8'(rsp_out_count));
               check_field("run_last", 8'(want.last), 8'(rsp_run_last));
               check_field("stream_done", 8'(want.done), 8'(rsp_stream_done));
               checked++;
            end
         end
         if (req_valid && req_ready) decode_byte(req_in_byte, req_stream_start);
      end
      pending = chunk_q.size();
   end

endmodule

### dv/tb_lzss_ring_dictionary_decoder_top.sv
// testbench top of the lzss ring dictionary decoder: stimulus, flow control and verdict
module tb_lzss_ring_dictionary_decoder_top;
   import lzssd_pkg::*;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_in_byte;
   logic       req_stream_start;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte_a;
   logic [7:0] rsp_out_byte_b;
   logic [1:0] rsp_out_count;
   logic       rsp_run_last;
   logic       rsp_stream_done;

   int fail_count;
   int pending;
   int chunks_checked;

   // flow control knobs, changed per phase
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   int items_sent   = 0;
   int streams_sent = 0;
   int phase_items;

   // compressed bytes of the stream about to be sent
   logic [7:0] stream_q[$];

   lzss_ring_dictionary_decoder_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_byte      (req_in_byte),
      .req_stream_start (req_stream_start),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte_a   (rsp_out_byte_a),
      .rsp_out_byte_b   (rsp_out_byte_b),
      .rsp_out_count    (rsp_out_count),
      .rsp_run_last     (rsp_run_last),
      .rsp_stream_done  (rsp_stream_done)
   );

   lzss_ring_dictionary_decoder_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_byte      (req_in_byte),
      .req_stream_start (req_stream_start),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte_a   (rsp_out_byte_a),
      .rsp_out_byte_b   (rsp_out_byte_b),
      .rsp_out_count    (rsp_out_count),
      .rsp_run_last     (rsp_run_last),
      .rsp_stream_done  (rsp_stream_done),
      .fail_count       (fail_count),
      .pending          (pending),
      .chunks_checked   (chunks_checked)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver side: ready is redrawn on every falling edge
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #20_000_000;
      $display("simulation failed");
      $finish;
   end

   // one byte transfer; entered and left on a falling edge, valid is only
   // lowered while the sender idles so it never toggles within one step
   task send_byte(input logic [7:0] b, input logic start);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_in_byte      <= b;
      req_stream_start <= start;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   // push the queued stream, stream_start only on its first byte if asked
   task send_stream(input bit marked);
      foreach (stream_q[i]) send_byte(stream_q[i], marked && i == 0);
      streams_sent++;
   endtask

   // hold the sender off until every predicted result has been transferred
   task drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
   endtask

   task push_size(input logic [31:0] size);
      stream_q.push_back(size[31:24]);
      stream_q.push_back(size[23:16]);
      stream_q.push_back(size[15:8]);
      stream_q.push_back(size[7:0]);
   endtask

   // well-formed stream of out_len decoded bytes: flag byte then up to eight tokens
   task build_stream(input int out_len);
      int          made;
      int          len;
      int          emitted;
      logic [7:0]  flags;
      logic [5:0]  len_code;
      logic [9:0]  off;
      logic [9:0]  gen_pos;
      made    = 0;
      gen_pos = WIN_START;
      stream_q = {};
      push_size(out_len + SIZE_BIAS);
      while (made < out_len) begin
         for (int k = 0; k < 8; k++) flags[k] = ($urandom_range(99) < 55);
         stream_q.push_back(flags);
         for (int k = 0; k < 8 && made < out_len; k++) begin
            if (flags[k]) begin
               stream_q.push_back(8'($urandom_range(255)));
               made++;
               gen_pos++;
            end else begin
               // mostly short copies from recent history, now and then long or far
               len_code = ($urandom_range(9) == 0) ? 6'($urandom_range(63))
                                                   : 6'($urandom_range(7));
               off = ($urandom_range(3) == 0) ? 10'($urandom_range(1023))
                                              : gen_pos - 10'($urandom_range(1, 48));
               stream_q.push_back({len_code, off[9:8]});
               stream_q.push_back(off[7:0]);
               len     = len_code + 3;
               emitted = (len < out_len - made) ? len : out_len - made;
               made    += emitted;
               gen_pos += 10'(emitted);
            end
         end
      end
   endtask

   // one random stream: mostly well formed, some cut short, some garbage
   task make_random_stream();
      int kind;
      int keep;
      kind = $urandom_range(99);
      if (kind < 6) begin
         // size at or below the bias, nothing to decode; trailing bytes are ignored
         stream_q = {};
         push_size($urandom_range(12));
         repeat ($urandom_range(2)) stream_q.push_back(8'($urandom_range(255)));
      end else if (kind < 14) begin
         // random header and random body bytes, abandoned by the next stream
         stream_q = {};
         push_size($urandom);
         repeat ($urandom_range(5, 30)) stream_q.push_back(8'($urandom_range(255)));
      end else begin
         build_stream(($urandom_range(9) == 0) ? $urandom_range(41, 250)
                                               : $urandom_range(1, 40));
         if (kind < 24) begin
            // broken stream: cut anywhere, the next stream_start abandons it
            keep = $urandom_range(1, stream_q.size() - 1);
            stream_q = stream_q[0:keep-1];
         end
         if (kind >= 24 && $urandom_range(9) < 3)
            repeat ($urandom_range(1, 3)) stream_q.push_back(8'($urandom_range(255)));
      end
   endtask

   initial begin
      req_valid        = 1'b0;
      req_in_byte      = 8'h00;
      req_stream_start = 1'b0;
      reset            = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // first stream without stream_start: reset already looks like a fresh
      // stream; size below the bias so nothing comes out
      stream_q = '{8'h00, 8'h00, 8'h00, 8'h0B};
      send_stream(1'b0);
      // length 7: the longest copy from the top of the window, cut short at the length;
      // the bytes after the end are ignored
      stream_q = '{8'h00, 8'h00, 8'h00, 8'h13, 8'h02, 8'hFF, 8'hFF, 8'hFF, 8'h00};
      send_stream(1'b1);
      // stream abandoned after its flag byte by the next stream_start
      stream_q = '{8'h00, 8'h00, 8'h01, 8'h00, 8'h00};
      send_stream(1'b1);
      // length 4: literal then an overlapping copy of itself with an odd byte count
      stream_q = '{8'h00, 8'h00, 8'h00, 8'h10, 8'h01, 8'h5A, 8'h03, 8'hBE};
      send_stream(1'b1);
      drain();

      // random phases: no idling, sender idle, receiver stalls, both
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 72; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 72; end
            default: begin send_idle_pct = 27; rsp_stall_pct = 27; end
         endcase
         phase_items = 0;
         while (phase_items < 72) begin
            make_random_stream();
            // the last stream of a phase is cut to the byte budget
            if (stream_q.size() > 72 - phase_items)
               stream_q = stream_q[0:71-phase_items];
            send_stream(1'b1);
            phase_items += stream_q.size();
         end
         drain();
      end

      // wait out the longest copy; give the block time to show stray results
      repeat (100) @(negedge clock);
      $display("covered %0d byte transfers in %0d streams with all idle patterns,",
               items_sent, streams_sent);
      $display("%0d result transfers checked against the decoded stream", chunks_checked);
      if (fail_count == 0 && pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### lzss_ring_dictionary_decoder_top.f
+incdir+design
design/lzssd_pkg.sv
design/lzssd_dict_ram.sv
design/lzssd_parser.sv
design/lzssd_engine.sv
design/lzss_ring_dictionary_decoder_top.sv
design/lzssd_checker.sv
dv/lzss_ring_dictionary_decoder_checker.sv
dv/tb_lzss_ring_dictionary_decoder_top.sv
